### rtl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// shared types and constants for the utf8 stream decoder
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int unsigned POINT_W         = 21;
    localparam int unsigned JOB_POINTS      = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [POINT_W-1:0] REPL_POINT = 21'h00FFFD;

    // one input word
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_word_t;

    // one output word
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               final_point;
    } point_word_t;

    // code points produced by one input word
    typedef struct packed {
        logic [JOB_POINTS-1:0][POINT_W-1:0] pts;
        logic [1:0]                         cnt;
        logic                               last;
    } job_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/utf8sd_front.sv
// ----------------------------------------------------------------------------
// utf8sd_front
// accepts text bytes, holds pending forms and builds decode jobs
// ----------------------------------------------------------------------------
module utf8sd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       text_valid,
    output logic                       text_stall,
    input  utf8sd_pkg::text_word_t     text,
    input  utf8sd_pkg::queue_status_t  q_status,
    output logic                       push,
    output utf8sd_pkg::job_t           push_job
);
    import utf8sd_pkg::*;

    logic [7:0] held_reg  [3];
    logic [7:0] held_next [3];
    logic [1:0] count_reg, count_next;
    logic [2:0] need_reg, need_next;

    logic       accept;
    logic [7:0] b;
    logic       last;
    logic       complete;
    logic [2:0] blen;
    logic [2:0] rlen;
    logic [7:0] r0;

    function automatic logic [2:0] lead_len(input logic [7:0] x);
        logic [2:0] len;
        if (x[7] == 1'b0)
            len = 3'd1;
        else if ((x & 8'hE0) == 8'hC0)
            len = 3'd2;
        else if ((x & 8'hF0) == 8'hE0)
            len = 3'd3;
        else if ((x & 8'hF8) == 8'hF0)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic [POINT_W-1:0] single(input logic [7:0] x);
        return x[7] ? REPL_POINT : {13'd0, x};
    endfunction

    assign text_stall = q_status.full;
    assign accept     = text_valid && !text_stall;
    assign b          = text.text_byte;
    assign last       = text.end_of_text;
    assign complete   = (count_reg != 2'd0) && (({1'b0, count_reg} + 3'd1) == need_reg);
    assign blen       = lead_len(b);
    assign r0         = (count_reg == 2'd1) ? b : held_reg[1];
    assign rlen       = lead_len(r0);

    always_comb
    begin
        push           = 1'b0;
        push_job.pts   = '0;
        push_job.cnt   = 2'd1;
        push_job.last  = last;
        held_next[0]   = held_reg[0];
        held_next[1]   = held_reg[1];
        held_next[2]   = held_reg[2];
        count_next     = count_reg;
        need_next      = need_reg;
        if (accept)
        begin
            if (count_reg == 2'd0)
            begin
                if (blen == 3'd1)
                begin
                    push            = 1'b1;
                    push_job.pts[0] = {13'd0, b};
                end
                else if (blen == 3'd0 || last)
                begin
                    push            = 1'b1;
                    push_job.pts[0] = REPL_POINT;
                end
                else
                begin
                    held_next[0] = b;
                    count_next   = 2'd1;
                    need_next    = blen;
                end
            end
            else if (complete)
            begin
                push       = 1'b1;
                count_next = 2'd0;
                need_next  = 3'd0;
                case (need_reg)
                    3'd2:    push_job.pts[0] = {10'd0, held_reg[0][4:0], b[5:0]};
                    3'd3:    push_job.pts[0] = {5'd0, held_reg[0][3:0], held_reg[1][5:0],
                                                b[5:0]};
                    default: push_job.pts[0] = {held_reg[0][2:0], held_reg[1][5:0],
                                                held_reg[2][5:0], b[5:0]};
                endcase
            end
            else if (!last)
            begin
                // form still short: append this byte
                if (count_reg == 2'd1)
                    held_next[1] = b;
                else
                    held_next[2] = b;
                count_next = count_reg + 2'd1;
            end
            else
            begin
                // text ends inside a form: lead is replaced, the rest re-decoded
                push            = 1'b1;
                count_next      = 2'd0;
                need_next       = 3'd0;
                push_job.pts[0] = REPL_POINT;
                if (count_reg == 2'd1)
                begin
                    push_job.pts[1] = single(b);
                    push_job.cnt    = 2'd2;
                end
                else if (rlen == 3'd1)
                begin
                    push_job.pts[1] = {13'd0, r0};
                    push_job.pts[2] = single(b);
                    push_job.cnt    = 2'd3;
                end
                else if (rlen == 3'd2)
                begin
                    push_job.pts[1] = {10'd0, r0[4:0], b[5:0]};
                    push_job.cnt    = 2'd2;
                end
                else
                begin
                    push_job.pts[1] = REPL_POINT;
                    push_job.pts[2] = single(b);
                    push_job.cnt    = 2'd3;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            need_reg  <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
            need_reg  <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg[0] <= held_next[0];
        held_reg[1] <= held_next[1];
        held_reg[2] <= held_next[2];
    end

    // a pending form is always shorter than its length
    a_held_short: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd0) |-> (({1'b0, count_reg} < need_reg) && (need_reg <= 3'd4)))
        else $error("held count not below needed length");

    // idle front has no pending length
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (need_reg == 3'd0))
        else $error("needed length set while nothing held");

    // the end mark always leaves the front idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (count_reg == 2'd0))
        else $error("state kept after end of text");

endmodule

### rtl/utf8sd_queue.sv
// ----------------------------------------------------------------------------
// utf8sd_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module utf8sd_queue #(
    parameter int unsigned DEPTH = utf8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  utf8sd_pkg::job_t           push_job,
    input  logic                       pop,
    output utf8sd_pkg::job_t           head_job,
    output utf8sd_pkg::queue_status_t  q_status
);
    import utf8sd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

endmodule

### rtl/utf8sd_back.sv
// ----------------------------------------------------------------------------
// utf8sd_back
// takes decode jobs and hands out their code points one word at a time
// ----------------------------------------------------------------------------
module utf8sd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  utf8sd_pkg::job_t           head_job,
    input  utf8sd_pkg::queue_status_t  q_status,
    output logic                       pop,
    output logic                       point_valid,
    input  logic                       point_stall,
    output utf8sd_pkg::point_word_t    point
);
    import utf8sd_pkg::*;

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       take, last_one, load;

    assign take     = cur_valid_reg && !point_stall;
    assign last_one = (idx_reg == (cur_reg.cnt - 2'd1));
    assign load     = !cur_valid_reg || (take && last_one);
    assign pop      = load && !q_status.empty;

    assign point_valid = cur_valid_reg;

    always_comb
    begin
        point.final_point = cur_reg.last && last_one;
        case (idx_reg)
            2'd0:    point.code_point = cur_reg.pts[0];
            2'd1:    point.code_point = cur_reg.pts[1];
            default: point.code_point = cur_reg.pts[2];
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (take && !last_one)
            idx_next = idx_reg + 2'd1;
        else if (load)
        begin
            cur_valid_next = !q_status.empty;
            cur_next       = head_job;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // the point index stays inside the job
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ((cur_reg.cnt != 2'd0) && (idx_reg < cur_reg.cnt)))
        else $error("point index outside job");

endmodule

### rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial utf8 decoder: text bytes in, code points out
//
// One text byte enters per word on the text channel, with end_of_text on the
// final byte of a text; decoded code points leave one per word on the point
// channel, final_point marking the last point of a text. Bytes below 0x80
// pass through; two, three and four byte forms are held until complete and
// then assembled without checking the following bytes, so overlong forms and
// surrogates come out as they are. A bad lead gives 0xFFFD for one byte. If a
// text ends inside a form, the lead gives 0xFFFD and the held bytes plus the
// final byte are decoded again, so one word can give up to three points.
// The front takes one word per cycle whenever the job queue has room; a byte
// that only extends a pending form gives no point. The back hands out one
// point per cycle while point_stall is low, so a word that ends a text
// inside a form holds the output for each of its points; the queue of
// QUEUE_DEPTH jobs between the two lets the input keep flowing while the
// output is stalled, until it fills. Jobs are registered in the queue, then the back.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = utf8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     text_valid,
    output logic                     text_stall,
    input  utf8sd_pkg::text_word_t   text,
    output logic                     point_valid,
    input  logic                     point_stall,
    output utf8sd_pkg::point_word_t  point
);
    import utf8sd_pkg::*;

    // front to queue
    logic          push;
    job_t          push_job;
    // queue to back
    logic          pop;
    job_t          head_job;
    // status shared by both sides
    queue_status_t q_status;

    // front: accepts bytes, tracks the pending form, builds one job per result
    utf8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    // queue: decouples the input stall from the output stall
    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // back: registered output, walks the points of each job
    utf8sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the utf8 stream decoder
//
// Text bytes go in on the text channel and every accepted word is run
// through a decoder model kept in the bench. Each code point that leaves on
// the point channel is compared, field by field, with the oldest expected
// point. A short directed part is followed by random text. Most of the
// random text is well-formed forms with random content. The rest is noise
// bytes, broken continuations and texts that end inside a form. Both sides
// pause at random, with stretches where they do not pause at all.
// ----------------------------------------------------------------------------
module tb;

    import utf8sd_pkg::*;

    localparam int unsigned RANDOM_WORDS = 400;
    localparam int unsigned IDLE_LIMIT   = 1000;  // cycles with no word moving
    localparam int unsigned DRAIN_CYCLES = 8;

    // ------------------------------------------------------------------------
    // decoder model and store of expected points
    // ------------------------------------------------------------------------
    class point_scoreboard;

        point_word_t  expected_points[$];
        logic [7:0]   pending_bytes[3];   // lead plus the following bytes so far
        int unsigned  pending_count;
        int unsigned  mismatches;
        int unsigned  points_checked;
        int unsigned  repl_points;

        function new();
            pending_count  = 0;
            mismatches     = 0;
            points_checked = 0;
            repl_points    = 0;
        endfunction

        // length of the form that a lead byte opens, 0 for a bad lead
        function int unsigned form_length(logic [7:0] b);
            casez (b)
                8'b0???????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 0;
            endcase
        endfunction

        // work out the points that one accepted word gives
        function void note_word(text_word_t w);
            logic [7:0]         bytes_in[4];
            point_word_t        made[3];
            logic [POINT_W-1:0] cp;
            int unsigned        n;
            int unsigned        i;
            int unsigned        k;
            int unsigned        len;
            int unsigned        produced;
            bit                 holding;

            n = 0;
            for (k = 0; k < pending_count; k++)
            begin
                bytes_in[n] = pending_bytes[k];
                n++;
            end
            bytes_in[n] = w.text_byte;
            n++;
            pending_count = 0;
            produced = 0;
            holding = 1'b0;
            i = 0;

            while (i < n && !holding)
            begin
                len = form_length(bytes_in[i]);
                if (len >= 2 && i + len > n)
                begin
                    if (!w.end_of_text)
                    begin
                        // form still open: keep what has come so far
                        for (k = 0; i + k < n && k < 3; k++)
                            pending_bytes[k] = bytes_in[i + k];
                        pending_count = k;
                        holding = 1'b1;
                    end
                    else
                    begin
                        // text ended inside the form: lead is replaced
                        cp = REPL_POINT;
                        i++;
                    end
                end
                else if (len == 0)
                begin
                    cp = REPL_POINT;
                    i++;
                end
                else
                begin
                    case (len)
                        1: cp = {13'b0, bytes_in[i]};
                        2: cp = {10'b0, bytes_in[i][4:0], bytes_in[i+1][5:0]};
                        3: cp = {5'b0, bytes_in[i][3:0], bytes_in[i+1][5:0],
                                 bytes_in[i+2][5:0]};
                        default: cp = {bytes_in[i][2:0], bytes_in[i+1][5:0],
                                       bytes_in[i+2][5:0], bytes_in[i+3][5:0]};
                    endcase
                    i += len;
                end
                if (!holding && produced < 3)
                begin
                    made[produced].code_point  = cp;
                    made[produced].final_point = 1'b0;
                    produced++;
                end
            end

            if (w.end_of_text && produced > 0)
                made[produced-1].final_point = 1'b1;
            for (k = 0; k < produced; k++)
                expected_points.insert(expected_points.size(), made[k]);
        endfunction

        // compare one accepted point with the oldest expected one
        function void check_point(point_word_t got);
            point_word_t exp_pt;

            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point cp=%h final=%b",
                             $realtime, got.code_point, got.final_point);
                return;
            end
            exp_pt = expected_points.pop_front();
            points_checked++;
            if (exp_pt.code_point == REPL_POINT)
                repl_points++;
            if (got.code_point !== exp_pt.code_point ||
                got.final_point !== exp_pt.final_point)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: point mismatch cp exp=%h got=%h final exp=%b got=%b",
                             $realtime, exp_pt.code_point, got.code_point,
                             exp_pt.final_point, got.final_point);
            end
        endfunction

        function int unsigned outstanding();
            return expected_points.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic         clk         = 1'b0;
    logic         rst_n       = 1'b0;
    logic         text_valid  = 1'b0;
    logic         text_stall;
    text_word_t   text        = '0;
    logic         point_valid;
    logic         point_stall = 1'b0;
    point_word_t  point;

    point_scoreboard sb = new();

    int unsigned  words_sent  = 0;
    int unsigned  texts_sent  = 0;
    int unsigned  idle_cycles = 0;
    bit           steady_in   = 1'b0;   // sender runs without gaps while set
    bit           steady_out  = 1'b0;   // receiver never stalls while set

    initial
    begin
        forever #2 clk = ~clk;
    end

    utf8_stream_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    // ------------------------------------------------------------------------
    // text side: one word per call, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eot);
        int unsigned gap;
        text_word_t  w;

        gap = steady_in ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0)
            steady_in = !steady_in;
        if (gap != 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        w.text_byte   = b;
        w.end_of_text = eot;
        text       <= w;
        text_valid <= 1'b1;
        // payload holds until the block takes it
        do
            @(posedge clk);
        while (text_stall);
        sb.note_word(w);
        words_sent++;
        if (eot)
            texts_sent++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // point side: stall for a random count, then take the next point
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;

        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = steady_out ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0)
                steady_out = !steady_out;
            if (hold != 0)
            begin
                point_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            point_stall <= 1'b0;
            do
                @(posedge clk);
            while (!point_valid);
            sb.check_point(point);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends a run in which no word moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (point_valid && !point_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        // {end_of_text, text_byte}
        static logic [8:0] directed_words[27] = '{
            9'h000, 9'h07F,                     // ascii extremes
            9'h0C2, 9'h0A9,                     // two byte form
            9'h0E2, 9'h082, 9'h0AC,             // three byte form
            9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,     // four byte form, top payload
            9'h080,                             // stray continuation
            9'h0C0, 9'h080,                     // overlong form passes
            9'h0ED, 9'h0A0, 9'h080,             // surrogate passes
            9'h0F0, 9'h09F, 9'h198,             // text ends in form: three points
            9'h0E2, 9'h1C3,                     // second lead caught in the cut
            9'h0F0, 9'h0C3, 9'h1A9,             // held bytes form a new two byte form
            9'h1C3,                             // lone lead ends the text
            9'h1F8                              // bad lead ends the text
        };
        logic [7:0]  byte_val;
        int unsigned form_len;
        int unsigned k;
        int unsigned failures;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[k])
            send_word(directed_words[k][7:0], directed_words[k][8]);

        // random text: mostly well-formed forms, some noise and broken forms
        while (words_sent < $size(directed_words) + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                byte_val = 8'($urandom_range(0, 255));
                send_word(byte_val, $urandom_range(0, 9) == 0);
            end
            else
            begin
                form_len = $urandom_range(1, 4);
                case (form_len)
                    1: byte_val = 8'($urandom_range(0, 127));
                    2: byte_val = 8'hC0 | 8'($urandom_range(0, 31));
                    3: byte_val = 8'hE0 | 8'($urandom_range(0, 15));
                    default: byte_val = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                send_word(byte_val, $urandom_range(0, 9) == 0);
                for (k = 1; k < form_len; k++)
                begin
                    // now and then a following byte that is no continuation
                    if ($urandom_range(0, 7) == 0)
                        byte_val = 8'($urandom_range(0, 255));
                    else
                        byte_val = 8'h80 | 8'($urandom_range(0, 63));
                    send_word(byte_val, $urandom_range(0, 9) == 0);
                end
            end
        end
        // close the last text so nothing stays held
        send_word(8'h2E, 1'b1);
        text_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        // catch any stray point after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        failures = sb.mismatches + sb.outstanding();
        if (sb.mismatches > 10)
            $display("%0d mismatches in total", sb.mismatches);
        if (sb.outstanding() != 0)
            $display("%0d expected points never arrived", sb.outstanding());
        $display("coverage: %0d text bytes in %0d texts, random pauses on both sides",
                 words_sent, texts_sent);
        $display("coverage: %0d code points compared, %0d of them replacement points",
                 sb.points_checked, sb.repl_points);
        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
